// File: rtl/morse_key_decoder_top_macros.svh
// Assertion macros shared by the Morse key decoder RTL.
`ifndef MORSE_KEY_DECODER_TOP_MACROS_SVH
`define MORSE_KEY_DECODER_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define MKD_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, once seen, forces another one on the next clock edge.
`define MKD_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mkd_pkg.sv
// Package with types, constants and the symbol table of the Morse key decoder.
package mkd_pkg;

	localparam int unsigned MAX_MARKS_DEF = 6;
	localparam int unsigned SYMBOL_COUNT  = 31;
	localparam int unsigned TABLE_LEN_MAX = 6;

	localparam logic [15:0] DASH_THRESHOLD_RST = 16'd200;
	localparam logic [15:0] LETTER_TIMEOUT_RST = 16'd700;
	localparam logic [7:0]  DEBOUNCE_TIME_RST  = 8'd30;

	typedef enum logic [1:0] {
		REG_DASH_THRESHOLD = 2'd0,
		REG_LETTER_TIMEOUT = 2'd1,
		REG_DEBOUNCE_TIME  = 2'd2
	} reg_index_t;

	typedef enum logic {
		KIND_CHAR     = 1'b0,
		KIND_LINE_END = 1'b1
	} kind_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] symbol;
	} lookup_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [4:0] symbol;
	} result_t;

	// Mark count of each symbol; the symbol code is the index.
	localparam logic [2:0] PAT_LEN [SYMBOL_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4,
		3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4,
		3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
		3'd4, 3'd4, 3'd6, 3'd5, 3'd6, 3'd6, 3'd6
	};

	// Mark pattern of each symbol, first mark in the highest used bit, dash is 1.
	localparam logic [5:0] PAT_BITS [SYMBOL_COUNT] = '{
		6'd1,  6'd8,  6'd10, 6'd4,  6'd0,  6'd2,  6'd6,  6'd0,
		6'd0,  6'd7,  6'd5,  6'd4,  6'd3,  6'd2,  6'd7,  6'd6,
		6'd13, 6'd2,  6'd0,  6'd1,  6'd1,  6'd1,  6'd3,  6'd9,
		6'd11, 6'd12, 6'd33, 6'd1,  6'd1,  6'd7,  6'd0
	};

endpackage

// File: rtl/mkd_lookup.sv
// Symbol table match of a finished mark pattern.
module mkd_lookup #(
	parameter int unsigned MAX_MARKS = mkd_pkg::MAX_MARKS_DEF
) (
	input  logic [$clog2(MAX_MARKS + 2)-1:0] count,
	input  logic [MAX_MARKS-1:0]             bits,
	output mkd_pkg::lookup_t                 result
);

	localparam int unsigned CW = $clog2(MAX_MARKS + 2);

	logic count_ok;

	assign count_ok = (count != '0) && (count <= CW'(mkd_pkg::TABLE_LEN_MAX));

	always_comb begin
		result = '0;
		for (int i = mkd_pkg::SYMBOL_COUNT - 1; i >= 0; i--) begin
			if (count_ok && (count == CW'(mkd_pkg::PAT_LEN[i]))
					&& (bits == MAX_MARKS'(mkd_pkg::PAT_BITS[i]))) begin
				result.hit    = 1'b1;
				result.symbol = 5'(i);
			end
		end
	end

endmodule

// File: rtl/mkd_core.sv
// Key debouncing, mark timing and pattern state of the Morse key decoder.
module mkd_core #(
	parameter int unsigned MAX_MARKS = mkd_pkg::MAX_MARKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              key,
	input  logic [15:0]       dash_threshold,
	input  logic [15:0]       letter_timeout,
	input  logic [7:0]        debounce_time,
	output mkd_pkg::result_t  result
);

	localparam int unsigned    CW       = $clog2(MAX_MARKS + 2);
	localparam logic [CW-1:0]  COUNT_MAX = CW'(MAX_MARKS);
	localparam logic [CW-1:0]  COUNT_OVF = CW'(MAX_MARKS + 1);

	logic                 key_held_q, key_held_n;
	logic [7:0]           since_edge_q, since_edge_n;
	logic [15:0]          press_length_q, press_length_n;
	logic [16:0]          since_release_q, since_release_n;
	logic [MAX_MARKS-1:0] mark_bits_q, mark_bits_n, bits_tmp;
	logic [CW-1:0]        mark_count_q, mark_count_n, count_tmp;
	logic                 letter_pending_q, letter_pending_n;
	logic                 line_pending_q, line_pending_n;
	logic                 deb_ok, press, release_edge, dash, letter_due, line_due;
	mkd_pkg::lookup_t     look;

	mkd_lookup #(.MAX_MARKS(MAX_MARKS)) u_lookup (
		.count  (count_tmp),
		.bits   (bits_tmp),
		.result (look)
	);

	always_comb begin
		since_edge_n    = (since_edge_q == 8'hFF) ? since_edge_q : since_edge_q + 8'd1;
		press_length_n  = (press_length_q == 16'hFFFF) ? press_length_q
				: press_length_q + 16'd1;
		since_release_n = (since_release_q == 17'h1FFFF) ? since_release_q
				: since_release_q + 17'd1;
		key_held_n       = key_held_q;
		letter_pending_n = letter_pending_q;
		line_pending_n   = line_pending_q;
		bits_tmp         = mark_bits_q;
		count_tmp        = mark_count_q;

		deb_ok       = since_edge_n > debounce_time;
		press        = key && !key_held_q && deb_ok;
		release_edge = !key && key_held_q && deb_ok;
		dash         = press_length_n >= dash_threshold;

		if (press) begin
			since_edge_n   = '0;
			key_held_n     = 1'b1;
			press_length_n = '0;
		end else if (release_edge) begin
			line_pending_n = 1'b1;
			since_edge_n   = '0;
			key_held_n     = 1'b0;
			if (mark_count_q < COUNT_MAX) begin
				bits_tmp  = {mark_bits_q[MAX_MARKS-2:0], dash};
				count_tmp = mark_count_q + CW'(1);
			end else begin
				count_tmp = COUNT_OVF;
			end
			since_release_n  = '0;
			letter_pending_n = 1'b1;
		end

		mark_bits_n  = bits_tmp;
		mark_count_n = count_tmp;
		result       = '0;

		letter_due = letter_pending_n && (since_release_n > {1'b0, letter_timeout});
		if (letter_due) begin
			mark_bits_n      = '0;
			mark_count_n     = '0;
			letter_pending_n = 1'b0;
			if (look.hit) begin
				result.valid  = 1'b1;
				result.kind   = mkd_pkg::KIND_CHAR;
				result.symbol = look.symbol;
			end
		end

		line_due = line_pending_n && (since_release_n > {letter_timeout, 1'b0});
		if (!result.valid && line_due) begin
			line_pending_n = 1'b0;
			result.valid   = 1'b1;
			result.kind    = mkd_pkg::KIND_LINE_END;
			result.symbol  = '0;
		end

		if (!step) begin
			result.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_held_q       <= 1'b0;
			since_edge_q     <= '0;
			press_length_q   <= '0;
			since_release_q  <= '0;
			mark_bits_q      <= '0;
			mark_count_q     <= '0;
			letter_pending_q <= 1'b0;
			line_pending_q   <= 1'b0;
		end else if (step) begin
			key_held_q       <= key_held_n;
			since_edge_q     <= since_edge_n;
			press_length_q   <= press_length_n;
			since_release_q  <= since_release_n;
			mark_bits_q      <= mark_bits_n;
			mark_count_q     <= mark_count_n;
			letter_pending_q <= letter_pending_n;
			line_pending_q   <= line_pending_n;
		end
	end

endmodule

// File: rtl/morse_key_decoder_top.sv
// Top level of the Morse key decoder: registers, input stage and result stage.
//
// The input channel (in_valid, in_stall, key_down) carries one item per
// millisecond tick with the sampled key level. An item is taken into an
// input register and processed there once the result stage can advance;
// a decoded character or an end of line is then written to the result
// register, which drives out_valid, kind and symbol. One tick is taken
// every cycle while in_stall is low.
// A tick that causes no result produces no output transfer.
// When out_stall holds a result, the result register keeps it and the input
// stage holds its tick; in_stall rises only while that tick is waiting.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is the dash threshold, 1 the letter timeout and
// 2 the debounce time. Other indexes are ignored.
// Reset clears the key state, the counters and the pattern, empties both
// stages and loads the register defaults 200, 700 and 30.
`include "morse_key_decoder_top_macros.svh"

module morse_key_decoder_top #(
	parameter int unsigned MAX_MARKS = mkd_pkg::MAX_MARKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        key_down,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [4:0]  symbol,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]      dash_threshold_q;
	logic [15:0]      letter_timeout_q;
	logic [7:0]       debounce_time_q;
	logic             valid_s1;
	logic             key_s1;
	logic             advance;
	logic             out_valid_q;
	logic             kind_q;
	logic [4:0]       symbol_q;
	mkd_pkg::result_t res;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_threshold_q <= mkd_pkg::DASH_THRESHOLD_RST;
			letter_timeout_q <= mkd_pkg::LETTER_TIMEOUT_RST;
			debounce_time_q  <= mkd_pkg::DEBOUNCE_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (mkd_pkg::reg_index_t'(cfg_index))
				mkd_pkg::REG_DASH_THRESHOLD: dash_threshold_q <= cfg_data;
				mkd_pkg::REG_LETTER_TIMEOUT: letter_timeout_q <= cfg_data;
				mkd_pkg::REG_DEBOUNCE_TIME:  debounce_time_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			key_s1 <= key_down;
		end
	end

	mkd_core #(.MAX_MARKS(MAX_MARKS)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (valid_s1 && advance),
		.key            (key_s1),
		.dash_threshold (dash_threshold_q),
		.letter_timeout (letter_timeout_q),
		.debounce_time  (debounce_time_q),
		.result         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q   <= res.kind;
			symbol_q <= res.symbol;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign symbol    = symbol_q;

	`MKD_CHECK_NEXT(a_held_result_kept, out_valid_q && out_stall, out_valid_q && $stable(symbol_q), "stalled result was lost")
	`MKD_CHECK(a_stall_needs_work, !in_stall || (valid_s1 && out_valid_q), "input stalled with no work held")
	`MKD_CHECK(a_line_end_symbol, !(out_valid_q && kind_q) || (symbol_q == 5'd0), "line end with nonzero symbol")
	`MKD_CHECK(a_symbol_range, !out_valid_q || (symbol_q <= 5'd30), "symbol code out of range")

endmodule
